// ----- rtl/core/fcts_pkg.sv -----
package fcts_pkg;

    // Input transaction kinds
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Channel selectors
    localparam logic [1:0] CH_PULSE0 = 2'd0;
    localparam logic [1:0] CH_PULSE1 = 2'd1;
    localparam logic [1:0] CH_TRI    = 2'd2;
    localparam logic [1:0] CH_NOISE  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SAMPLE_STEP = 2'd0;
    localparam logic [1:0] REG_LOWPASS     = 2'd1;
    localparam logic [1:0] REG_HIGHPASS    = 2'd2;
    localparam logic [1:0] REG_GAIN        = 2'd3;

    // Divider operand widths
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_Q_W   = 17;

    typedef logic [10:0] timer_tbl_t [128];
    typedef logic [3:0]  vol_tbl_t [128];
    typedef logic [11:0] noise_tbl_t [16];
    typedef logic [31:0] ratio_tbl_t [12];

    localparam noise_tbl_t NOISE_TBL = '{
        12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
        12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};

    // Bit s of entry d is the level of duty d at sequencer step s
    localparam logic [7:0] DUTY_BITS [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    // 2^(i/12) in Q8.24
    localparam ratio_tbl_t SEMI_RATIO = '{
        32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
        32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
        32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166};

    localparam longint unsigned PULSE_DEN = 64'd7040 << 29;
    localparam longint unsigned TRI_DEN   = 64'd7040 << 30;

    function automatic longint unsigned key_num(input int key);
        int d;
        d = 129 - key;
        return (64'd1789773 * 64'(SEMI_RATIO[d % 12])) << (d / 12);
    endfunction

    function automatic timer_tbl_t build_pulse_tbl();
        timer_tbl_t       t;
        longint unsigned  v;
        for (int k = 0; k < 128; k++)
        begin
            v = (key_num(k) + PULSE_DEN / 2) / PULSE_DEN;
            if (v < 64'd9)
                t[k] = 11'd8;
            else if (v > 64'd2048)
                t[k] = 11'd2047;
            else
                t[k] = 11'(v - 64'd1);
        end
        return t;
    endfunction

    function automatic timer_tbl_t build_tri_tbl();
        timer_tbl_t       t;
        longint unsigned  v;
        for (int k = 0; k < 128; k++)
        begin
            v = (key_num(k) + TRI_DEN / 2) / TRI_DEN;
            if (v < 64'd3)
                t[k] = 11'd2;
            else if (v > 64'd2048)
                t[k] = 11'd2047;
            else
                t[k] = 11'(v - 64'd1);
        end
        return t;
    endfunction

    function automatic vol_tbl_t build_vol_tbl();
        vol_tbl_t t;
        for (int k = 0; k < 128; k++)
        begin
            t[k] = 4'((k * 15 + 63) / 127);
        end
        return t;
    endfunction

    localparam timer_tbl_t PULSE_TBL = build_pulse_tbl();
    localparam timer_tbl_t TRI_TBL   = build_tri_tbl();
    localparam vol_tbl_t   VOL_TBL   = build_vol_tbl();

endpackage

// ----- rtl/core/four_channel_tone_synth_top.sv -----
// Channel    | period source             | level
// pulse one  | key table, clamp 8..2047  | duty pattern x volume
// pulse two  | key table, clamp 8..2047  | duty pattern x volume
// triangle   | key table, clamp 2..2047  | 32-step triangle
// noise      | key-48 into period table  | 15-bit LFSR x volume
//
// Note-on, note-off and unused commands leave ready high.
// A tick runs the mix through the shared 17-step divider, one pass for each
// nonzero mix term (pulse, then triangle and noise); a silent term skips its pass.
// A tick that ends a sample period adds the averaging pass and the filter states
// (low-pass, high-pass, gain) before the sample is written out.
// A finished sample waits in the output register; the block stalls at the
// end of the next sample if that one is still not taken.
// Reset is asynchronous, active low, and loads all channel and filter state.
module four_channel_tone_synth_top
    import fcts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // note_key[6:0], velocity[13:7], duty[15:14]
    input  logic [15:0] s_axis_tdata,
    // command[1:0], channel[3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pcm_sample[15:0]
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PHASE_W = 25;
    localparam logic [PHASE_W-1:0] ONE_CYCLE = PHASE_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MIX, S_PNUM, S_PDIV, S_TNUM, S_TDIV, S_ACC,
        S_AVG, S_AVG_DIV, S_LP, S_LP2, S_HP, S_HP2, S_GAIN, S_PCM
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [23:0] sample_step_reg;
    logic [15:0] lowpass_coef_reg, highpass_coef_reg, output_gain_reg;

    // Channel state
    logic [10:0] pulse_period_reg [2];
    logic [10:0] pulse_count_reg [2];
    logic [2:0]  pulse_step_reg [2];
    logic [1:0]  pulse_duty_reg [2];
    logic [3:0]  pulse_volume_reg [2];
    logic [1:0]  pulse_on_reg;
    logic        half_reg;
    logic [10:0] tri_period_reg, tri_count_reg;
    logic [4:0]  tri_step_reg;
    logic        tri_on_reg;
    logic [3:0]  noise_volume_reg;
    logic [11:0] noise_period_reg, noise_count_reg;
    logic [14:0] noise_lfsr_reg;
    logic        noise_short_reg, noise_on_reg;

    // Mix and filter state
    logic [21:0]        mix_sum_reg;
    logic [5:0]         mix_ticks_reg;
    logic [PHASE_W-1:0] sample_phase_reg;
    logic               due_reg;
    logic [4:0]         p_reg;
    logic [18:0]        s_reg;
    logic [16:0]        raw_reg;
    logic [16:0]        avg_reg;
    logic [15:0]        lowpass_level_reg, highpass_prev_in_reg;
    logic signed [17:0] highpass_out_reg;
    logic signed [34:0] lp_prod_reg;
    logic signed [36:0] hp_prod_reg;
    logic signed [34:0] m_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    // Input fields
    cmd_t       in_cmd;
    logic [1:0] in_ch, in_duty;
    logic [6:0] in_key, in_vel;
    logic       in_accept;

    assign in_cmd    = cmd_t'(s_axis_tuser[1:0]);
    assign in_ch     = s_axis_tuser[3:2];
    assign in_key    = s_axis_tdata[6:0];
    assign in_vel    = s_axis_tdata[13:7];
    assign in_duty   = s_axis_tdata[15:14];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAMPLE_STEP: prdata = {8'd0, sample_step_reg};
            REG_LOWPASS:     prdata = {16'd0, lowpass_coef_reg};
            REG_HIGHPASS:    prdata = {16'd0, highpass_coef_reg};
            REG_GAIN:        prdata = {16'd0, output_gain_reg};
        endcase
    end

    // Noise period index and sample phase
    logic [3:0]         noise_idx;
    logic [PHASE_W-1:0] step_eff, phase_sum;

    always_comb
    begin
        if (in_key < 7'd48)
            noise_idx = 4'd0;
        else if (in_key > 7'd63)
            noise_idx = 4'd15;
        else
            noise_idx = 4'(in_key - 7'd48);
        step_eff  = ({1'b0, sample_step_reg} < ONE_CYCLE) ? ONE_CYCLE
                                                          : {1'b0, sample_step_reg};
        phase_sum = sample_phase_reg + ONE_CYCLE;
    end

    // Channel levels after the timers have advanced
    logic [4:0]  p_comb;
    logic [3:0]  tr_lvl, ns_lvl;
    logic [18:0] s_comb;

    always_comb
    begin
        p_comb = '0;
        for (int i = 0; i < 2; i++)
        begin
            if (pulse_on_reg[i] && DUTY_BITS[pulse_duty_reg[i]][pulse_step_reg[i]])
                p_comb = p_comb + {1'b0, pulse_volume_reg[i]};
        end
        tr_lvl = !tri_on_reg ? 4'd0
               : (tri_step_reg[4] ? tri_step_reg[3:0] : ~tri_step_reg[3:0]);
        ns_lvl = (noise_on_reg && !noise_lfsr_reg[0]) ? noise_volume_reg : 4'd0;
        s_comb = 19'(tr_lvl) * 19'd12241 + 19'(ns_lvl) * 19'd8227;
    end

    // Divider operands for each pass
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_Q_W-1:0]   div_quot;
    logic [20:0]          p_den;
    logic [DIV_DEN_W-1:0] t_den;

    always_comb
    begin
        p_den     = 21'd812800 + 21'(p_reg) * 21'd10000;
        t_den     = 34'd10070610700 + 34'(s_reg) * 34'd10000;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_PNUM:
            begin
                div_start = (p_reg != 5'd0);
                div_num   = DIV_NUM_W'({19'(p_reg) * 19'd9588, 16'd0})
                          + DIV_NUM_W'(p_den[20:1]);
                div_den   = DIV_DEN_W'(p_den);
            end
            S_TNUM:
            begin
                div_start = (s_reg != 19'd0);
                div_num   = DIV_NUM_W'({33'(s_reg) * 33'd15979, 16'd0})
                          + DIV_NUM_W'(t_den[DIV_DEN_W-1:1]);
                div_den   = t_den;
            end
            S_AVG:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(mix_sum_reg) + DIV_NUM_W'(mix_ticks_reg[5:1]);
                div_den   = DIV_DEN_W'(mix_ticks_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    fcts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Filter arithmetic
    logic signed [17:0] lp_diff;
    logic signed [18:0] lp_r;
    logic signed [19:0] lp_t;
    logic signed [19:0] hp_t;
    logic signed [20:0] hp_r;
    logic signed [49:0] pcm_wide;
    logic signed [49:0] pcm_adj;
    logic [15:0]        pcm_val;

    always_comb
    begin
        lp_diff  = $signed({1'b0, avg_reg}) - $signed({2'b0, lowpass_level_reg});
        lp_r     = 19'((lp_prod_reg + 35'sd32768) >>> 16);
        lp_t     = $signed({4'b0, lowpass_level_reg}) + 20'(lp_r);
        hp_t     = 20'(highpass_out_reg) + $signed({4'b0, lowpass_level_reg})
                 - $signed({4'b0, highpass_prev_in_reg});
        hp_r     = 21'((hp_prod_reg + 37'sd32768) >>> 16);
        pcm_wide = (50'(m_reg) <<< 15) - 50'(m_reg);
        pcm_adj  = pcm_wide[49] ? pcm_wide + 50'sd268435455 : pcm_wide;
        if (m_reg >= 35'sd268435456)
            pcm_val = 16'sd32767;
        else if (m_reg <= -35'sd268435456)
            pcm_val = -16'sd32767;
        else
            pcm_val = 16'(pcm_adj >>> 28);
    end

    // Sequencer, channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sample_step_reg   <= 24'd2443637;
            lowpass_coef_reg  <= 16'd51912;
            highpass_coef_reg <= 16'd65208;
            output_gain_reg   <= 16'd11469;
            for (int i = 0; i < 2; i++)
            begin
                pulse_period_reg[i] <= '0;
                pulse_count_reg[i]  <= '0;
                pulse_step_reg[i]   <= '0;
                pulse_duty_reg[i]   <= 2'd2;
                pulse_volume_reg[i] <= 4'd12;
            end
            pulse_on_reg         <= '0;
            half_reg             <= 1'b0;
            tri_period_reg       <= '0;
            tri_count_reg        <= '0;
            tri_step_reg         <= '0;
            tri_on_reg           <= 1'b0;
            noise_volume_reg     <= 4'd10;
            noise_period_reg     <= 12'd4;
            noise_count_reg      <= '0;
            noise_lfsr_reg       <= 15'd1;
            noise_short_reg      <= 1'b0;
            noise_on_reg         <= 1'b0;
            mix_sum_reg          <= '0;
            mix_ticks_reg        <= '0;
            sample_phase_reg     <= '0;
            due_reg              <= 1'b0;
            p_reg                <= '0;
            s_reg                <= '0;
            raw_reg              <= '0;
            avg_reg              <= '0;
            lowpass_level_reg    <= '0;
            highpass_prev_in_reg <= '0;
            highpass_out_reg     <= '0;
            lp_prod_reg          <= '0;
            hp_prod_reg          <= '0;
            m_reg                <= '0;
            out_valid_reg        <= 1'b0;
            out_data_reg         <= '0;
        end
        else
        begin
            // Drop the sample once taken, unless a new one lands this cycle
            if (m_axis_tready && state_reg != S_PCM)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_SAMPLE_STEP: sample_step_reg   <= pwdata[23:0];
                    REG_LOWPASS:     lowpass_coef_reg  <= pwdata[15:0];
                    REG_HIGHPASS:    highpass_coef_reg <= pwdata[15:0];
                    REG_GAIN:        output_gain_reg   <= pwdata[15:0];
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (in_cmd)
                            CMD_ON:
                            begin
                                if (in_ch == CH_PULSE0 || in_ch == CH_PULSE1)
                                begin
                                    pulse_on_reg[in_ch[0]]     <= 1'b1;
                                    pulse_duty_reg[in_ch[0]]   <= in_duty;
                                    pulse_volume_reg[in_ch[0]] <= VOL_TBL[in_vel];
                                    pulse_step_reg[in_ch[0]]   <= '0;
                                    pulse_period_reg[in_ch[0]] <= PULSE_TBL[in_key];
                                    pulse_count_reg[in_ch[0]]  <= PULSE_TBL[in_key];
                                end
                                else if (in_ch == CH_TRI)
                                begin
                                    tri_on_reg     <= 1'b1;
                                    tri_step_reg   <= '0;
                                    tri_period_reg <= TRI_TBL[in_key];
                                    tri_count_reg  <= TRI_TBL[in_key];
                                end
                                else
                                begin
                                    noise_on_reg     <= 1'b1;
                                    noise_volume_reg <= VOL_TBL[in_vel];
                                    noise_period_reg <= NOISE_TBL[noise_idx];
                                    noise_count_reg  <= NOISE_TBL[noise_idx];
                                    noise_short_reg  <= in_key[6];
                                end
                            end
                            CMD_OFF:
                            begin
                                if (in_ch == CH_PULSE0 || in_ch == CH_PULSE1)
                                    pulse_on_reg[in_ch[0]] <= 1'b0;
                                else if (in_ch == CH_TRI)
                                    tri_on_reg <= 1'b0;
                                else
                                    noise_on_reg <= 1'b0;
                            end
                            CMD_TICK:
                            begin
                                // Advance timers, sequencers and the LFSR
                                for (int i = 0; i < 2; i++)
                                begin
                                    if (pulse_on_reg[i] && half_reg)
                                    begin
                                        if (pulse_count_reg[i] != 11'd0)
                                            pulse_count_reg[i] <= pulse_count_reg[i] - 11'd1;
                                        else
                                        begin
                                            pulse_count_reg[i] <= pulse_period_reg[i];
                                            pulse_step_reg[i]  <= pulse_step_reg[i] + 3'd1;
                                        end
                                    end
                                end
                                half_reg <= ~half_reg;
                                if (tri_on_reg)
                                begin
                                    if (tri_count_reg != 11'd0)
                                        tri_count_reg <= tri_count_reg - 11'd1;
                                    else
                                    begin
                                        tri_count_reg <= tri_period_reg;
                                        tri_step_reg  <= tri_step_reg + 5'd1;
                                    end
                                end
                                if (noise_on_reg)
                                begin
                                    if (noise_count_reg != 12'd0)
                                        noise_count_reg <= noise_count_reg - 12'd1;
                                    else
                                    begin
                                        noise_count_reg <= noise_period_reg;
                                        noise_lfsr_reg  <= {noise_lfsr_reg[0] ^
                                            (noise_short_reg ? noise_lfsr_reg[6]
                                                             : noise_lfsr_reg[1]),
                                            noise_lfsr_reg[14:1]};
                                    end
                                end
                                // Advance the sample phase
                                if (phase_sum >= step_eff)
                                begin
                                    sample_phase_reg <= phase_sum - step_eff;
                                    due_reg          <= 1'b1;
                                end
                                else
                                begin
                                    sample_phase_reg <= phase_sum;
                                    due_reg          <= 1'b0;
                                end
                                state_reg <= S_MIX;
                            end
                            CMD_NONE:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MIX:
                begin
                    p_reg     <= p_comb;
                    s_reg     <= s_comb;
                    raw_reg   <= '0;
                    state_reg <= S_PNUM;
                end
                S_PNUM:
                begin
                    state_reg <= (p_reg != 5'd0) ? S_PDIV : S_TNUM;
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        raw_reg   <= div_quot;
                        state_reg <= S_TNUM;
                    end
                end
                S_TNUM:
                begin
                    state_reg <= (s_reg != 19'd0) ? S_TDIV : S_ACC;
                end
                S_TDIV:
                begin
                    if (div_done)
                    begin
                        raw_reg   <= raw_reg + div_quot;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    // Hold the average once 63 ticks are in
                    if (mix_ticks_reg < 6'd63)
                    begin
                        mix_sum_reg   <= mix_sum_reg + 22'(raw_reg);
                        mix_ticks_reg <= mix_ticks_reg + 6'd1;
                    end
                    state_reg <= due_reg ? S_AVG : S_IDLE;
                end
                S_AVG:
                begin
                    state_reg <= S_AVG_DIV;
                end
                S_AVG_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg       <= div_quot;
                        mix_sum_reg   <= '0;
                        mix_ticks_reg <= '0;
                        state_reg     <= S_LP;
                    end
                end
                S_LP:
                begin
                    lp_prod_reg <= $signed({19'd0, lowpass_coef_reg}) * 35'(lp_diff);
                    state_reg   <= S_LP2;
                end
                S_LP2:
                begin
                    if (lp_t < 20'sd0)
                        lowpass_level_reg <= '0;
                    else if (lp_t > 20'sd65535)
                        lowpass_level_reg <= 16'hFFFF;
                    else
                        lowpass_level_reg <= lp_t[15:0];
                    state_reg <= S_HP;
                end
                S_HP:
                begin
                    hp_prod_reg <= $signed({21'd0, highpass_coef_reg}) * 37'(hp_t);
                    state_reg   <= S_HP2;
                end
                S_HP2:
                begin
                    if (hp_r > 21'sd131071)
                        highpass_out_reg <= 18'sd131071;
                    else if (hp_r < -21'sd131072)
                        highpass_out_reg <= -18'sd131072;
                    else
                        highpass_out_reg <= hp_r[17:0];
                    highpass_prev_in_reg <= lowpass_level_reg;
                    state_reg            <= S_GAIN;
                end
                S_GAIN:
                begin
                    m_reg     <= 35'(highpass_out_reg) * $signed({19'd0, output_gain_reg});
                    state_reg <= S_PCM;
                end
                S_PCM:
                begin
                    // Wait for the output slot to free up
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= pcm_val;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/core/fcts_div.sv -----
module fcts_div
    import fcts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quot
);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   sh_reg, sh_next;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;

    // One restoring step: shift in the next dividend bit, try a subtract
    always_comb
    begin
        trial = {rem_reg, sh_reg[DIV_Q_W-1]} - {1'b0, den_reg};
        if (!trial[DIV_DEN_W])
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            sh_next  = {sh_reg[DIV_Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[DIV_DEN_W-2:0], sh_reg[DIV_Q_W-1]};
            sh_next  = {sh_reg[DIV_Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // Quotient fits in DIV_Q_W bits, so the upper part is below den
                rem_reg  <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
                sh_reg   <= num[DIV_Q_W-1:0];
                den_reg  <= den;
                cnt_reg  <= 5'(DIV_Q_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                sh_reg  <= sh_next;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- rtl/core/fcts_checker.sv -----
module fcts_checker
    import fcts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A held sample stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output sample dropped or changed while stalled");

    // A tick keeps the block busy for the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == CMD_TICK |=> !s_axis_tready)
        else $error("ready after a tick transaction");

    // The clamp never yields the most negative code
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("sample outside the clamp range");

    // A transaction other than a tick never raises a sample on the next cycle
    a_note_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] != CMD_TICK && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("sample raised by a note transaction");

endmodule

bind four_channel_tone_synth_top fcts_checker u_fcts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/four_channel_tone_synth_top_tb.sv -----
`timescale 1ns / 1ps

module four_channel_tone_synth_top_tb
    import fcts_pkg::*;
;

    localparam int  ONE_CYCLE   = 1 << 16;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  CYCLE_LIMIT = 2000000;

    // Stimulus row: expected sample typed in only where it is obvious
    typedef struct {
        cmd_t       cmd;
        logic [1:0] ch;
        int         key;
        int         vel;
        int         duty;
        bit         typed;
        logic [15:0] pcm;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    four_channel_tone_synth_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    // Own copies of the package tables
    int unsigned noise_periods [16] = '{4, 8, 16, 32, 64, 96, 128, 160,
                                        202, 254, 380, 508, 762, 1016, 2034, 4068};
    logic [7:0]  duty_pattern [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};
    longint unsigned semitone_q24 [12] = '{
        16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
        23726566, 25137421, 26632170, 28215802, 29893600, 31671166};

    // Idle percentages of each phase
    int idle_send [6] = '{0, 88, 0, 16, 0, 88};
    int idle_recv [6] = '{0, 0, 88, 16, 88, 0};

    // Synth state, mirrored
    logic [23:0] cfg_step = 24'd2443637;
    logic [15:0] cfg_lp = 16'd51912;
    logic [15:0] cfg_hp = 16'd65208;
    logic [15:0] cfg_gain = 16'd11469;
    int unsigned pl_period [2] = '{0, 0};
    int unsigned pl_count [2] = '{0, 0};
    int unsigned pl_seq [2] = '{0, 0};
    int unsigned pl_duty [2] = '{2, 2};
    int unsigned pl_vol [2] = '{12, 12};
    bit          pl_on [2] = '{0, 0};
    int unsigned tr_period = 0, tr_count = 0, tr_seq = 0;
    bit          tr_on = 0;
    int unsigned nz_vol = 10, nz_period = 4, nz_count = 0, nz_lfsr = 1;
    bit          nz_short = 0, nz_on = 0;
    int unsigned acc_sum = 0, acc_n = 0, phase_acc = 0, lp_level = 0, hp_prev = 0;
    longint      hp_out = 0;
    bit          half_clk = 0;

    logic [15:0] pcm_pending [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic int unsigned note_period(input int key, input int extra,
                                                input int unsigned floor_val);
        int              d;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        d   = 129 - key;
        num = (64'd1789773 * semitone_q24[d % 12]) << (d / 12);
        den = 64'd7040 << (29 + extra);
        v   = (num + den / 2) / den;
        if (v < floor_val + 1)
            return floor_val;
        if (v > 2048)
            return 2047;
        return int'(v - 1);
    endfunction

    function automatic int unsigned mix_q16(input int unsigned p, input int unsigned tri_lvl,
                                            input int unsigned nz_lvl);
        longint unsigned q;
        longint unsigned s;
        longint unsigned d;
        q = 0;
        s = longint'(tri_lvl) * 12241 + longint'(nz_lvl) * 8227;
        if (p != 0)
        begin
            d = 812800 + 10000 * longint'(p);
            q += (64'd9588 * p * 65536 + d / 2) / d;
        end
        if (s != 0)
        begin
            d = 64'd10070610700 + 10000 * s;
            q += (64'd15979 * s * 65536 + d / 2) / d;
        end
        return int'(q);
    endfunction

    // Advance the synth by one transaction; returns 1 when a sample comes out
    function automatic bit synth_advance(input cmd_t cmd, input logic [1:0] ch, input int key,
                                         input int vel, input int dty,
                                         output logic [15:0] pcm);
        int unsigned vol;
        int unsigned idx;
        int unsigned p;
        int unsigned tri_lvl;
        int unsigned nz_lvl;
        int unsigned fb;
        int unsigned step;
        int unsigned avg;
        longint      t;
        longint      m;
        longint      res;
        vol = (vel * 15 + 63) / 127;
        pcm = '0;
        if (cmd == CMD_ON)
        begin
            if (ch == CH_PULSE0 || ch == CH_PULSE1)
            begin
                pl_on[ch] = 1; pl_duty[ch] = dty; pl_vol[ch] = vol; pl_seq[ch] = 0;
                pl_period[ch] = note_period(key, 0, 8);
                pl_count[ch] = pl_period[ch];
            end
            else if (ch == CH_TRI)
            begin
                tr_on = 1; tr_seq = 0;
                tr_period = note_period(key, 1, 2);
                tr_count = tr_period;
            end
            else
            begin
                idx = key < 48 ? 0 : (key - 48 > 15 ? 15 : key - 48);
                nz_on = 1; nz_vol = vol; nz_period = noise_periods[idx];
                nz_count = nz_period; nz_short = key >= 64;
            end
            return 0;
        end
        if (cmd == CMD_OFF)
        begin
            if (ch == CH_PULSE0 || ch == CH_PULSE1)
                pl_on[ch] = 0;
            else if (ch == CH_TRI)
                tr_on = 0;
            else
                nz_on = 0;
            return 0;
        end
        if (cmd != CMD_TICK)
            return 0;

        // Clock timers; pulse runs at half rate
        for (int i = 0; i < 2; i++)
        begin
            if (pl_on[i] && half_clk)
            begin
                if (pl_count[i] > 0)
                    pl_count[i]--;
                else
                begin
                    pl_count[i] = pl_period[i];
                    pl_seq[i] = (pl_seq[i] + 1) & 7;
                end
            end
        end
        half_clk = ~half_clk;
        if (tr_on)
        begin
            if (tr_count > 0)
                tr_count--;
            else
            begin
                tr_count = tr_period;
                tr_seq = (tr_seq + 1) & 31;
            end
        end
        if (nz_on)
        begin
            if (nz_count > 0)
                nz_count--;
            else
            begin
                fb = (nz_lfsr ^ (nz_lfsr >> (nz_short ? 6 : 1))) & 1;
                nz_count = nz_period;
                nz_lfsr = ((nz_lfsr >> 1) | (fb << 14)) & 32'h7FFF;
            end
        end

        // Mix and accumulate
        p = 0;
        for (int i = 0; i < 2; i++)
            if (pl_on[i] && duty_pattern[pl_duty[i]][pl_seq[i]])
                p += pl_vol[i];
        tri_lvl = tr_on ? (tr_seq < 16 ? 15 - tr_seq : tr_seq - 16) : 0;
        nz_lvl = (nz_on && (nz_lfsr & 1) == 0) ? nz_vol : 0;
        if (acc_n < 63)
        begin
            acc_sum += mix_q16(p, tri_lvl, nz_lvl);
            acc_n++;
        end
        step = cfg_step < ONE_CYCLE ? ONE_CYCLE : cfg_step;
        phase_acc += ONE_CYCLE;
        if (phase_acc < step)
            return 0;
        phase_acc -= step;

        // Average, filter, gain
        avg = acc_n != 0 ? (acc_sum + acc_n / 2) / acc_n : 0;
        acc_sum = 0; acc_n = 0;
        t = longint'(lp_level) + ((longint'(cfg_lp) * (longint'(avg) - longint'(lp_level))
            + 32768) >>> 16);
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        lp_level = int'(t);
        t = hp_out + longint'(lp_level) - longint'(hp_prev);
        t = (longint'(cfg_hp) * t + 32768) >>> 16;
        if (t > 131071) t = 131071;
        if (t < -131072) t = -131072;
        hp_out = t;
        hp_prev = lp_level;
        m = hp_out * longint'(cfg_gain);
        if (m >= (longint'(1) << 28))
            res = 32767;
        else if (m <= -(longint'(1) << 28))
            res = -32767;
        else
            res = (m * 32767) / (longint'(1) << 28);
        pcm = res[15:0];
        return 1;
    endfunction

    // Drive one transaction and record what it should produce
    task automatic send_item(input stim_row_t row);
        logic [15:0] pcm;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.duty[1:0], row.vel[6:0], row.key[6:0]};
        s_axis_tuser  <= {row.ch, row.cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (synth_advance(row.cmd, row.ch, row.key, row.vel, row.duty, pcm))
            pcm_pending = {pcm_pending, (row.typed ? row.pcm : pcm)};
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pcm_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SAMPLE_STEP: cfg_step = val[23:0];
            REG_LOWPASS:     cfg_lp   = val[15:0];
            REG_HIGHPASS:    cfg_hp   = val[15:0];
            default:         cfg_gain = val[15:0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] step, input logic [31:0] lp,
                              input logic [31:0] hp, input logic [31:0] gain);
        write_reg(REG_SAMPLE_STEP, step);
        write_reg(REG_LOWPASS, lp);
        write_reg(REG_HIGHPASS, hp);
        write_reg(REG_GAIN, gain);
    endtask

    function automatic stim_row_t random_row();
        stim_row_t r;
        int        pick;
        pick = $urandom_range(99);
        r.cmd = pick < 80 ? CMD_TICK : (pick < 89 ? CMD_ON : (pick < 96 ? CMD_OFF : CMD_NONE));
        r.ch = 2'($urandom_range(3));
        r.key = $urandom_range(127);
        r.vel = $urandom_range(127);
        r.duty = $urandom_range(3);
        r.typed = 0;
        r.pcm = '0;
        return r;
    endfunction

    // Receiver stalls at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each sample with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pcm_pending.size() == 0)
            begin
                $error("pcm_sample: unexpected transaction, got %0d", $signed(m_axis_tdata));
                fail_count++;
            end
            else if (pcm_pending[0] !== m_axis_tdata)
            begin
                $error("pcm_sample: expected %0d, got %0d",
                       $signed(pcm_pending[0]), $signed(m_axis_tdata));
                fail_count++;
                void'(pcm_pending.pop_front());
            end
            else
                void'(pcm_pending.pop_front());
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    stim_row_t directed [] = '{
        // directed unit: the two opening ticks, all channels silent, expect zero
        '{CMD_TICK, CH_PULSE0, 0, 0, 0, 1, 16'd0},
        '{CMD_TICK, CH_NOISE, 127, 127, 3, 1, 16'd0},
        '{CMD_OFF, CH_TRI, 60, 64, 1, 0, 16'd0},
        '{CMD_NONE, CH_NOISE, 127, 127, 3, 0, 16'd0},
        '{CMD_ON, CH_PULSE0, 0, 127, 0, 0, 16'd0},
        '{CMD_TICK, CH_PULSE0, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_PULSE1, 127, 0, 3, 0, 16'd0},
        '{CMD_TICK, CH_PULSE1, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_PULSE1, 69, 127, 1, 0, 16'd0},
        '{CMD_ON, CH_TRI, 0, 0, 0, 0, 16'd0},
        '{CMD_TICK, CH_TRI, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_TRI, 127, 127, 2, 0, 16'd0},
        '{CMD_TICK, CH_TRI, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_NOISE, 0, 127, 0, 0, 16'd0},
        '{CMD_TICK, CH_NOISE, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_NOISE, 127, 1, 0, 0, 16'd0},
        '{CMD_TICK, CH_NOISE, 0, 0, 0, 0, 16'd0},
        '{CMD_ON, CH_NOISE, 64, 100, 0, 0, 16'd0},
        '{CMD_TICK, CH_PULSE0, 0, 0, 0, 0, 16'd0},
        '{CMD_OFF, CH_PULSE0, 0, 0, 0, 0, 16'd0},
        '{CMD_OFF, CH_PULSE1, 0, 0, 0, 0, 16'd0},
        '{CMD_OFF, CH_TRI, 0, 0, 0, 0, 16'd0},
        '{CMD_OFF, CH_NOISE, 0, 0, 0, 0, 16'd0},
        '{CMD_TICK, CH_PULSE0, 0, 0, 0, 0, 16'd0}
    };

    initial
    begin
        int sent;
        stim_row_t row;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Step below one cycle: a sample on every tick
        write_reg(REG_SAMPLE_STEP, 32'd0);
        foreach (directed[i])
            send_item(directed[i]);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(32'd65536, 32'd65535, 32'd65535, 32'd65535);
                1: set_config(32'd2443637, $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(65535));
                2: set_config(32'hFFFFFF, 32'd0, 32'd0, 32'd0);
                3: set_config($urandom_range(400000, 65536), $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(65535));
                4: set_config(32'd100000, $urandom_range(65535), 32'd65208, 32'd65535);
                default: set_config($urandom_range(16777215, 65536), 32'd51912,
                                    $urandom_range(65535), 32'd11469);
            endcase
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            sent = 0;
            while (sent < 230)
            begin
                row = random_row();
                send_item(row);
                if (row.cmd != CMD_NONE)
                    sent++;
                // Hold off once until the output side is empty
                if (ph == 3 && sent == 100)
                begin
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pcm_pending.size() != 0);
                end
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
